/* hdl/blist_pkg.sv */
// Shared types and constants of the bounded list with overwrite.
package blist_pkg;

	typedef logic [3:0] req_code_t;

	localparam req_code_t REQ_READ_AT    = 4'd0;
	localparam req_code_t REQ_PEEK_FIRST = 4'd1;
	localparam req_code_t REQ_PEEK_LAST  = 4'd2;
	localparam req_code_t REQ_ADD_FIRST  = 4'd3;
	localparam req_code_t REQ_ADD_LAST   = 4'd4;
	localparam req_code_t REQ_TAKE_FIRST = 4'd5;
	localparam req_code_t REQ_TAKE_LAST  = 4'd6;
	localparam req_code_t REQ_TAKE_AT    = 4'd7;
	localparam req_code_t REQ_TAKE_VALUE = 4'd8;

	typedef struct packed {
		req_code_t   req_type;
		logic [3:0]  position;
		logic [31:0] word_in;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] word_out;
		logic        dropped;
		logic [31:0] dropped_word;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		SEL_ZERO  = 3'd0,
		SEL_POS   = 3'd1,
		SEL_LAST  = 3'd2,
		SEL_IDX   = 3'd3,
		SEL_IDX1  = 3'd4,
		SEL_TOP   = 3'd5,
		SEL_COUNT = 3'd6
	} sel_t;

	typedef struct packed {
		logic load_req;
		logic rd_en;
		sel_t rd_sel;
		logic wr_en;
		sel_t wr_sel;
		logic wr_from_ram;
		logic cap_found;
		logic cap_dropped;
		logic head_inc;
		logic head_dec;
		logic count_inc;
		logic count_dec;
		logic idx_load_pos;
		logic idx_clear;
		logic idx_inc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		req_code_t req;
		logic      full;
		logic      empty;
		logic      pos_ok;
		logic      idx1_lt;
		logic      idx2_lt;
		logic      match;
		logic      out_free;
	} stat_t;

endpackage

/* hdl/blist_chan_if.sv */
// Valid/ready channel interface carrying one payload per transaction.
interface blist_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/blist_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module blist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

/* hdl/blist_ctrl.sv */
// Controller state machine that sequences each list request.
module blist_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  blist_pkg::stat_t stat,
	output blist_pkg::cmd_t  cmd
);
	import blist_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECODE = 8'b0000_0010,
		ST_FETCH  = 8'b0000_0100,
		ST_SH_RD  = 8'b0000_1000,
		ST_SH_WR  = 8'b0001_0000,
		ST_SC_RD  = 8'b0010_0000,
		ST_SC_CMP = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_FINISH;
				unique case (stat.req)
					REQ_READ_AT: begin
						if (stat.pos_ok) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = SEL_POS;
							state_d    = ST_FETCH;
						end
					end
					REQ_PEEK_FIRST, REQ_TAKE_FIRST: begin
						if (!stat.empty) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = SEL_ZERO;
							state_d    = ST_FETCH;
						end
					end
					REQ_PEEK_LAST, REQ_TAKE_LAST: begin
						if (!stat.empty) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = SEL_LAST;
							state_d    = ST_FETCH;
						end
					end
					REQ_ADD_FIRST: begin
						cmd.rd_en  = stat.full;
						cmd.rd_sel = SEL_TOP;
						state_d    = ST_FETCH;
					end
					REQ_ADD_LAST: begin
						cmd.rd_en  = stat.full;
						cmd.rd_sel = SEL_ZERO;
						state_d    = ST_FETCH;
					end
					REQ_TAKE_AT: begin
						if (stat.pos_ok) begin
							cmd.rd_en        = 1'b1;
							cmd.rd_sel       = SEL_POS;
							cmd.idx_load_pos = 1'b1;
							state_d          = ST_FETCH;
						end
					end
					REQ_TAKE_VALUE: begin
						if (!stat.empty) begin
							cmd.idx_clear = 1'b1;
							state_d       = ST_SC_RD;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_FETCH: begin
				state_d = ST_FINISH;
				unique case (stat.req)
					REQ_READ_AT, REQ_PEEK_FIRST, REQ_PEEK_LAST: begin
						cmd.cap_found = 1'b1;
					end
					REQ_TAKE_FIRST: begin
						cmd.cap_found = 1'b1;
						cmd.head_inc  = 1'b1;
						cmd.count_dec = 1'b1;
					end
					REQ_TAKE_LAST: begin
						cmd.cap_found = 1'b1;
						cmd.count_dec = 1'b1;
					end
					REQ_ADD_FIRST: begin
						cmd.cap_dropped = stat.full;
						cmd.wr_en       = 1'b1;
						cmd.wr_sel      = SEL_TOP;
						cmd.head_dec    = 1'b1;
						cmd.count_inc   = !stat.full;
					end
					REQ_ADD_LAST: begin
						cmd.cap_dropped = stat.full;
						cmd.wr_en       = 1'b1;
						cmd.wr_sel      = SEL_COUNT;
						cmd.head_inc    = stat.full;
						cmd.count_inc   = !stat.full;
					end
					REQ_TAKE_AT: begin
						cmd.cap_found = 1'b1;
						if (stat.idx1_lt) begin
							state_d = ST_SH_RD;
						end else begin
							cmd.count_dec = 1'b1;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_SH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_IDX1;
				state_d    = ST_SH_WR;
			end
			ST_SH_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = SEL_IDX;
				cmd.wr_from_ram = 1'b1;
				cmd.idx_inc     = 1'b1;
				if (stat.idx2_lt) begin
					state_d = ST_SH_RD;
				end else begin
					cmd.count_dec = 1'b1;
					state_d       = ST_FINISH;
				end
			end
			ST_SC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SEL_IDX;
				state_d    = ST_SC_CMP;
			end
			ST_SC_CMP: begin
				if (stat.match) begin
					cmd.cap_found = 1'b1;
					if (stat.idx1_lt) begin
						state_d = ST_SH_RD;
					end else begin
						cmd.count_dec = 1'b1;
						state_d       = ST_FINISH;
					end
				end else if (stat.idx1_lt) begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SC_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_shift_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_WR) |-> ($past(state_q) == ST_SH_RD))
		else $error("Shift write without a preceding shift read.");

	a_fetch_follows_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> ($past(state_q) == ST_DECODE))
		else $error("Fetch state entered from somewhere other than decode.");
`endif
endmodule

/* hdl/blist_datapath.sv */
// Datapath: request registers, circular list storage, pointers and result register.
module blist_datapath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  blist_pkg::cmd_t  cmd,
	output blist_pkg::stat_t stat,
	input  blist_pkg::req_t  req_data,
	output blist_pkg::rsp_t  rsp_data,
	output logic             rsp_valid,
	input  logic             rsp_ready
);
	import blist_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam int SW = AW + 1;

	req_code_t             req_code_q;
	logic [3:0]            pos_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic                  res_found_q;
	logic [DATA_WIDTH-1:0] res_word_q;
	logic                  res_dropped_q;
	logic [DATA_WIDTH-1:0] res_drop_word_q;
	logic                  out_valid_q;
	rsp_t                  out_data_q;

	logic [PW-1:0]         pos_ext;
	logic [CW-1:0]         count_m1;
	logic [CW-1:0]         idx_p1;
	logic [CW:0]           idx_p2;
	logic [CW-1:0]         rd_li;
	logic [CW-1:0]         wr_li;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [63:0]           word_wide;
	logic [63:0]           res_word_wide;
	logic [63:0]           drop_word_wide;
	logic [15:0]           count_wide;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [CW-1:0] li);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(li);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [CW-1:0] pick(input sel_t sel, input logic [CW-1:0] pos_idx,
			input logic [CW-1:0] last, input logic [CW-1:0] idx,
			input logic [CW-1:0] idx1, input logic [CW-1:0] cnt);
		logic [CW-1:0] li;
		unique case (sel)
			SEL_ZERO:  li = '0;
			SEL_POS:   li = pos_idx;
			SEL_LAST:  li = last;
			SEL_IDX:   li = idx;
			SEL_IDX1:  li = idx1;
			SEL_TOP:   li = CW'(DEPTH - 1);
			SEL_COUNT: li = cnt;
			default:   li = '0;
		endcase
		return li;
	endfunction

	assign pos_ext  = PW'(pos_q);
	assign count_m1 = count_q - CW'(1);
	assign idx_p1   = idx_q + CW'(1);
	assign idx_p2   = (CW + 1)'(idx_q) + (CW + 1)'(2);

	assign rd_li   = pick(cmd.rd_sel, pos_ext[CW-1:0], count_m1, idx_q, idx_p1, count_q);
	assign wr_li   = pick(cmd.wr_sel, pos_ext[CW-1:0], count_m1, idx_q, idx_p1, count_q);
	assign rd_addr = phys(head_q, rd_li);
	assign wr_addr = phys(head_q, wr_li);
	assign wr_data = cmd.wr_from_ram ? ram_rdata : word_q;

	blist_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		stat          = '0;
		stat.req      = req_code_q;
		stat.full     = (count_q == CW'(DEPTH));
		stat.empty    = (count_q == '0);
		stat.pos_ok   = (pos_ext < PW'(count_q));
		stat.idx1_lt  = (idx_p1 < count_q);
		stat.idx2_lt  = (idx_p2 < (CW + 1)'(count_q));
		stat.match    = (ram_rdata == word_q);
		stat.out_free = !out_valid_q || rsp_ready;
	end

	assign word_wide = 64'(req_data.word_in);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_code_q <= req_data.req_type;
			pos_q      <= req_data.position;
			word_q     <= word_wide[DATA_WIDTH-1:0];
		end
		if (cmd.load_req) begin
			res_found_q     <= 1'b0;
			res_word_q      <= '0;
			res_dropped_q   <= 1'b0;
			res_drop_word_q <= '0;
		end else begin
			if (cmd.cap_found) begin
				res_found_q <= 1'b1;
				res_word_q  <= ram_rdata;
			end
			if (cmd.cap_dropped) begin
				res_dropped_q   <= 1'b1;
				res_drop_word_q <= ram_rdata;
			end
		end
		if (cmd.idx_load_pos) begin
			idx_q <= pos_ext[CW-1:0];
		end else if (cmd.idx_clear) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.head_inc) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end else if (cmd.head_dec) begin
				head_q <= (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
			end
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_m1;
			end
		end
	end

	assign res_word_wide  = 64'(res_word_q);
	assign drop_word_wide = 64'(res_drop_word_q);
	assign count_wide     = 16'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.found        <= res_found_q;
			out_data_q.word_out     <= res_word_wide[31:0];
			out_data_q.dropped      <= res_dropped_q;
			out_data_q.dropped_word <= drop_word_wide[31:0];
			out_data_q.entry_count  <= count_wide[4:0];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Entry count exceeds the list depth.");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_dec |-> (count_q != '0))
		else $error("Entry count decremented on an empty list.");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("Result register loaded while a transaction is still pending.");
`endif
endmodule

/* hdl/bounded_list_with_overwrite.sv */
// Bounded ordered list with overwrite: one request transaction in, one result out.
// Reads, peeks, inserts, end removals: decode, fetch, then finish; rejected requests skip fetch.
// take_at then moves each entry behind the index forward one place, one at a time through the RAM;
// take_value reads and compares entries in order from the first, then does that shift after a match.
// One request at a time: the next is accepted the cycle after the result is stored.
// Reset clears the entry count, head pointer and control; storage is not cleared.
module bounded_list_with_overwrite #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	blist_chan_if.sink   req,
	blist_chan_if.source rsp
);
	import blist_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	blist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	blist_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req.data),
		.rsp_data  (rsp.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready)
	);

	assign req.ready = in_ready;
endmodule
